// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SPG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define SPG_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/spg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spg_pkg;

  localparam logic [8:0]  MAX_COLOURS  = 9'd256;
  localparam logic [8:0]  COUNT_RESET  = 9'd180;
  localparam logic        REG_COUNT    = 1'b0;

  localparam logic [16:0] HUMP_A       = 17'd22643;
  localparam logic [16:0] HUMP_B       = 17'd59279;
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [18:0] THREE_Q16    = 19'd196608;

  localparam int          X_BITS       = 17;

  // (1-a)^2 (1-b)^2 in Q32 after the shift
  localparam logic [63:0] HUMP_P1      = 64'd268381501 * 64'd268381501;
  localparam logic [31:0] HUMP_D       = HUMP_P1[63:32];

  // ceil(2^56 / HUMP_D) is 2^32 plus this low part, exact for numerators below 2^32
  localparam logic [63:0] BLUE_RECIP   = ((64'd1 << 56) + {32'd0, HUMP_D} - 64'd1)
                                         / {32'd0, HUMP_D};
  localparam logic [20:0] BLUE_RECIP_C = BLUE_RECIP[20:0];

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic        lsb;
    logic [7:0]  rem;
    logic [16:0] quo;
  } spg_div_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [53:0] rem;
    logic [8:0]  quo;
  } spg_blue_t;

endpackage

`default_nettype wire

// ----- sv/spg_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spg_div_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [7:0]       m,
  input  spg_pkg::spg_div_t     d_in,
  output spg_pkg::spg_div_t     d_out
);

  logic [8:0]        sh;
  logic              ge;
  logic [8:0]        diff;
  spg_pkg::spg_div_t d_next;

  assign sh   = {d_in.rem, d_in.lsb};
  assign ge   = sh >= {1'b0, m};
  assign diff = sh - {1'b0, m};

  always_comb begin
    d_next       = d_in;
    d_next.lsb   = 1'b0;
    d_next.rem   = ge ? diff[7:0] : sh[7:0];
    d_next.quo   = {d_in.quo[15:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= d_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/spg_curve.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spg_curve (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  spg_pkg::spg_div_t     x_in,
  output spg_pkg::spg_blue_t    b_out
);

  logic [16:0] x_c;
  logic [18:0] x4_c;
  logic [24:0] red_c;

  logic        v_1, v_2, v_3, v_4, v_5;
  logic [16:0] x_1, x_2, x_3, x_4;
  logic [7:0]  red_1, red_2, red_3, red_4, red_5;
  logic [17:0] t_1;
  logic [15:0] da_1, db_1;
  logic [35:0] t2_2;
  logic [31:0] p_2;
  logic [34:0] xh_3, xl_3;
  logic [63:0] pp_3;
  logic [55:0] gs_4;
  logic [28:0] u_4;
  logic [63:0] g255_c;
  logic [7:0]  green_5;
  logic [45:0] ux_5;
  logic [53:0] n_c;

  assign x_c   = x_in.zero ? 17'd0 : x_in.quo;
  assign x4_c  = {x_c, 2'b00};
  assign red_c = {x_c, 8'd0} - {8'd0, x_c};

  assign g255_c = {gs_4, 8'd0} - {8'd0, gs_4};
  assign n_c    = {ux_5, 8'd0} - {8'd0, ux_5};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_1 <= 1'b0;
      v_2 <= 1'b0;
      v_3 <= 1'b0;
      v_4 <= 1'b0;
      v_5 <= 1'b0;
      b_out.valid <= 1'b0;
    end else if (en) begin
      v_1 <= x_in.valid;
      v_2 <= v_1;
      v_3 <= v_2;
      v_4 <= v_3;
      v_5 <= v_4;
      b_out.valid <= v_5;
      x_1   <= x_c;
      red_1 <= red_c[23:16];
      t_1   <= (x4_c >= spg_pkg::THREE_Q16) ? 18'(x4_c - spg_pkg::THREE_Q16)
                                            : 18'(spg_pkg::THREE_Q16 - x4_c);
      da_1  <= (x_c >= spg_pkg::HUMP_A) ? 16'(x_c - spg_pkg::HUMP_A)
                                        : 16'(spg_pkg::HUMP_A - x_c);
      db_1  <= (x_c >= spg_pkg::HUMP_B) ? 16'(x_c - spg_pkg::HUMP_B)
                                        : 16'(spg_pkg::HUMP_B - x_c);
      x_2   <= x_1;
      red_2 <= red_1;
      t2_2  <= t_1 * t_1;
      p_2   <= da_1 * db_1;
      // x * t^2 split in two partial products
      x_3   <= x_2;
      red_3 <= red_2;
      xh_3  <= x_2 * t2_2[35:18];
      xl_3  <= x_2 * t2_2[17:0];
      pp_3  <= p_2 * p_2;
      x_4   <= x_3;
      red_4 <= red_3;
      gs_4  <= {3'd0, xh_3, 18'd0} + {21'd0, xl_3};
      u_4   <= pp_3[60:32];
      red_5 <= red_4;
      green_5 <= (g255_c[63:56] != 8'd0) ? 8'hFF : g255_c[55:48];
      ux_5  <= u_4 * x_4;
      b_out.red   <= red_5;
      b_out.green <= green_5;
      b_out.rem   <= n_c;
      b_out.quo   <= 9'd0;
    end
  end

endmodule

`default_nettype wire

// ----- sv/spg_blue_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spg_blue_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  spg_pkg::spg_blue_t    b_in,
  output spg_pkg::spg_blue_t    b_out
);

  logic        v_1;
  logic [7:0]  red_1;
  logic [7:0]  green_1;
  logic        ovf_1;
  logic [31:0] m_1;
  logic [52:0] mc_1;
  logic [64:0] sum_c;

  // m / D as m * (2^32 + c) >> 56, exact for m below 2^32
  assign sum_c = {1'b0, m_1, 32'd0} + {12'd0, mc_1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_1 <= 1'b0;
      b_out.valid <= 1'b0;
    end else if (en) begin
      v_1     <= b_in.valid;
      red_1   <= b_in.red;
      green_1 <= b_in.green;
      // numerator over 2^16; anything from 2^32 up is far past full scale
      ovf_1   <= b_in.rem[53:48] != 6'd0;
      m_1     <= b_in.rem[47:16];
      mc_1    <= b_in.rem[47:16] * spg_pkg::BLUE_RECIP_C;
      b_out.valid <= v_1;
      b_out.red   <= red_1;
      b_out.green <= green_1;
      b_out.rem   <= 54'd0;
      b_out.quo   <= ovf_1 ? 9'h100 : sum_c[64:56];
    end
  end

endmodule

`default_nettype wire

// ----- sv/spectrum_palette_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pseudo-colour palette: one colour index per clock in, one red/green/blue request out
// per index. A new index is taken every cycle while the output is not held; the whole
// pipe freezes while out_stall holds a waiting result. The pipe is 17 restoring-divider
// cells forming x = index/(count-1), 6 curve stages and 2 stages that scale blue by a
// reciprocal multiply. colour_count sits at byte address 0 of the APB port; write it
// only while no request is in flight, which the block itself does not enforce.

`include "assert_macros.svh"

module spectrum_palette_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  colour_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [8:0]  colour_count;
  logic [8:0]  n_sat;
  logic [8:0]  n_dec;
  logic [7:0]  cfg_m;
  logic        en;
  logic [7:0]  idx_c;

  spg_pkg::spg_div_t  div_s  [0:spg_pkg::X_BITS];
  spg_pkg::spg_blue_t blue_c;
  spg_pkg::spg_blue_t blue_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == spg_pkg::REG_COUNT) ? {23'd0, colour_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_count <= spg_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == spg_pkg::REG_COUNT)) begin
      colour_count <= pwdata[8:0];
    end
  end

  assign n_sat = (colour_count > spg_pkg::MAX_COLOURS) ? spg_pkg::MAX_COLOURS : colour_count;
  assign n_dec = n_sat - 9'd1;
  assign cfg_m = n_dec[7:0];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign idx_c = (colour_index > cfg_m) ? cfg_m : colour_index;

  // top quotient bits are known zero since index <= count-1
  always_comb begin
    div_s[0].valid = in_valid;
    div_s[0].zero  = n_sat < 9'd2;
    div_s[0].lsb   = idx_c[0];
    div_s[0].rem   = {1'b0, idx_c[7:1]};
    div_s[0].quo   = 17'd0;
  end

  for (genvar k = 0; k < spg_pkg::X_BITS; k++) begin : g_div
    spg_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .m     (cfg_m),
      .d_in  (div_s[k]),
      .d_out (div_s[k+1])
    );
  end

  spg_curve u_curve (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .x_in  (div_s[spg_pkg::X_BITS]),
    .b_out (blue_c)
  );

  // blue normalization, quotient bit 8 flags saturation
  spg_blue_cell u_blue (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .b_in  (blue_c),
    .b_out (blue_q)
  );

  assign out_valid = blue_q.valid;
  assign red       = blue_q.red;
  assign green     = blue_q.green;
  assign blue      = blue_q.quo[8] ? 8'hFF : blue_q.quo[7:0];

  `SPG_CHECK(a_div_rem, div_s[spg_pkg::X_BITS].valid && !div_s[spg_pkg::X_BITS].zero |-> div_s[spg_pkg::X_BITS].rem < cfg_m, "divider remainder not below divisor")
  `SPG_CHECK(a_x_range, div_s[spg_pkg::X_BITS].valid && !div_s[spg_pkg::X_BITS].zero |-> div_s[spg_pkg::X_BITS].quo <= spg_pkg::ONE_Q16, "position above one")
  `SPG_CHECK_RST(a_rst_idle, rst |=> !out_valid, "result valid after reset")

endmodule

`default_nettype wire

// ----- tb/spg_checker.sv -----
`timescale 1ns / 1ps

module spg_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  colour_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [8:0]  colour_count,
  output int          fail_count,
  output int          pending,
  output int          colour_checks
);

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  rgb_t expected_rgb[$];

  function automatic logic [63:0] hump_diff(input logic [63:0] p, input logic [63:0] q);
    return (p >= q) ? p - q : q - p;
  endfunction

  // floor((x-a)^2 (x-b)^2 / 2^32)
  function automatic logic [63:0] double_hump(input logic [63:0] x);
    logic [63:0] da, db;
    da = hump_diff(x, 64'd22643);
    db = hump_diff(x, 64'd59279);
    return ((da * da) * (db * db)) >> 32;
  endfunction

  function automatic rgb_t palette_entry(input logic [8:0] count, input logic [7:0] index);
    logic [63:0] n, idx, x, t, g, u, d, bl;
    rgb_t c;
    n = count;
    idx = index;
    x = 0;
    if (n > 256) n = 256;
    if (n >= 2) begin
      if (idx > n - 1) idx = n - 1;
      x = (idx << 16) / (n - 1);
    end
    c.r = 8'((x * 255) >> 16);
    t = hump_diff(4 * x, 64'd196608);
    g = (x * (t * t) * 255) >> 48;
    c.g = (g > 255) ? 8'd255 : g[7:0];
    u = double_hump(x);
    d = double_hump(64'd65536);
    bl = (u * x * 255) / (d << 16);
    c.b = (bl > 255) ? 8'd255 : bl[7:0];
    return c;
  endfunction

  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      fail_count <= 0;
      colour_checks <= 0;
      pending <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_rgb.push_back(palette_entry(colour_count, colour_index));
      if (out_valid && !out_stall) begin
        colour_checks <= colour_checks + 1;
        if (expected_rgb.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected request out: %0d %0d %0d", red, green, blue);
        end else begin
          want = expected_rgb.pop_front();
          if (want.r !== red || want.g !== green || want.b !== blue) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch exp r%0d g%0d b%0d got r%0d g%0d b%0d",
                       want.r, want.g, want.b, red, green, blue);
          end
        end
      end
      pending <= expected_rgb.size();
    end
  end

endmodule

// ----- tb/tb_spectrum_palette_generator.sv -----
`timescale 1ns / 1ps

module tb_spectrum_palette_generator;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  colour_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red, green, blue;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [8:0]  colour_count = spg_pkg::COUNT_RESET;
  int          fail_count, pending, colour_checks;
  int          send_idle = 0, stall_pct = 0, hold_cycles = 0;
  longint      cycle = 0;

  always #5 clk = ~clk;

  spectrum_palette_generator i_dut (.*);

  spg_checker i_checker (.*);

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_index(input logic [7:0] idx);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    colour_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_count(input logic [8:0] value);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {spg_pkg::REG_COUNT, 2'b00}; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    colour_count <= value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [8:0] counts[8];
    counts = '{9'd180, 9'd2, 9'd256, 9'd0, 9'd1, 9'd511, 9'd3, 9'd100};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: field extremes at reset count, then at a list of counts including the extremes
    foreach (counts[k]) begin
      if (k > 0) begin
        settle();
        write_count(counts[k]);
      end
      send_index(8'd0); send_index(8'd255); send_index(8'd1);
      send_index(8'd128); send_index(8'd170);
    end
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      write_count((ph % 3 == 0) ? 9'($urandom_range(2, 256)) : 9'($urandom_range(511)));
      case (ph % 4)
        0: begin send_idle = 0; stall_pct = 0; end
        1: begin send_idle = 64; stall_pct = 0; end
        2: begin send_idle = 0; stall_pct = 64; end
        default: begin send_idle = 21; stall_pct = 21; end
      endcase
      if (ph == 4) hold_cycles <= 200;
      for (int i = 0; i < 215; i++) send_index(8'($urandom));
    end
    send_idle = 0; stall_pct = 0;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d palette requests over directed and random count settings",
             colour_checks);
    $display("with four idle mixes and one long receiver hold-off");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
